@@ src/arp_pkg.sv @@
// ----------------------------------------------------------------------------
// arp_pkg
// Shared types and constants for the AUIPC pair relocator.
// ----------------------------------------------------------------------------
package arp_pkg;

   localparam int HW_W        = 16;
   localparam int WORD_W      = 32;
   localparam int MAX_RESULTS = 4;
   localparam int Q_DEPTH     = 16;
   localparam int Q_AW        = $clog2(Q_DEPTH);
   localparam int Q_CW        = $clog2(Q_DEPTH + 1);
   // room for one item in the input register plus one being accepted
   localparam int RDY_LIMIT   = Q_DEPTH - 2 * MAX_RESULTS;

   localparam int PADDR_W     = 3;

   localparam logic [6:0] OPC_AUIPC = 7'h17;
   localparam logic [1:0] LEN_32    = 2'b11;

   localparam logic [PADDR_W-3:0] REG_SHIFT_AMOUNT = '0;

   typedef enum logic [2:0] {
      POS_START = 3'd0,
      POS_PLAIN = 3'd1,
      POS_PAIR1 = 3'd2,
      POS_PAIR2 = 3'd3,
      POS_PAIR3 = 3'd4
   } pos_type;

   typedef struct packed {
      logic [HW_W-1:0] halfword;
      logic            patched;
      logic            last;
   } result_type;

   typedef struct packed {
      logic [2:0]                   num;
      result_type [MAX_RESULTS-1:0] item;
   } push_type;

endpackage

@@ src/arp_if.sv @@
// ----------------------------------------------------------------------------
// arp_if
// Valid/ready channels for code halfwords in and relocated halfwords out.
// ----------------------------------------------------------------------------
interface arp_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] code_halfword;

   modport source (output valid, output code_halfword, input ready);
   modport sink   (input valid, input code_halfword, output ready);
endinterface

interface arp_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] out_halfword;
   logic        was_patched;
   logic        last_of_run;

   modport source (output valid, output out_halfword, output was_patched,
                   output last_of_run, input ready);
   modport sink   (input valid, input out_halfword, input was_patched,
                   input last_of_run, output ready);
endinterface

@@ src/riscv_auipc_pair_relocator.sv @@
// ----------------------------------------------------------------------------
// riscv_auipc_pair_relocator
// Relocates AUIPC/next-instruction pairs in a halfword code stream.
// ----------------------------------------------------------------------------
// channel   direction  item
// req_chan  in         one code halfword
// rsp_chan  out        one output halfword with patched and last-of-run flags
// csr       APB        shift_amount at byte address 0
//
// One halfword is accepted per cycle while req_chan.ready is high; from the
// input register its results go into the result queue, which hands them
// out one per cycle while rsp_chan.ready is high. A 16-bit instruction gives
// one result, a plain 32-bit one two, an AUIPC pair four, after its last
// halfword. The 16-entry result queue stalls input when it holds more than
// 8 entries. Synchronous reset clears the position tracker and the queue.
// ----------------------------------------------------------------------------
module riscv_auipc_pair_relocator
   import arp_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   arp_req_if.sink             req_chan,
   arp_rsp_if.source           rsp_chan,
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [PADDR_W-1:0]  paddr,
   input  logic [WORD_W-1:0]   pwdata,
   output logic [WORD_W-1:0]   prdata,
   output logic                pready
);

   logic [WORD_W-1:0] shift_amount;
   logic [Q_CW-1:0]   q_count;
   push_type          push;

   arp_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .psel         (psel),
      .penable      (penable),
      .pwrite       (pwrite),
      .paddr        (paddr),
      .pwdata       (pwdata),
      .prdata       (prdata),
      .pready       (pready),
      .shift_amount (shift_amount)
   );

   arp_core u_core (
      .clock        (clock),
      .reset        (reset),
      .req_chan     (req_chan),
      .shift_amount (shift_amount),
      .q_count      (q_count),
      .push         (push)
   );

   arp_outq u_outq (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .rsp_chan (rsp_chan),
      .q_count  (q_count)
   );

endmodule

@@ src/arp_csr.sv @@
// ----------------------------------------------------------------------------
// arp_csr
// APB register file holding the relocation displacement.
// ----------------------------------------------------------------------------
module arp_csr
   import arp_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [PADDR_W-1:0]  paddr,
   input  logic [WORD_W-1:0]   pwdata,
   output logic [WORD_W-1:0]   prdata,
   output logic                pready,
   output logic [WORD_W-1:0]   shift_amount
);

   logic [WORD_W-1:0] shift_ff;
   logic [WORD_W-1:0] shift_in;
   logic              sel_shift;

   assign pready    = 1'b1;
   assign sel_shift = (paddr[PADDR_W-1:2] == REG_SHIFT_AMOUNT);

   always_comb begin
      shift_in = shift_ff;
      if (psel && penable && pwrite && pready && sel_shift) begin
         shift_in = pwdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff <= '0;
      end else begin
         shift_ff <= shift_in;
      end
   end

   assign prdata       = sel_shift ? shift_ff : '0;
   assign shift_amount = shift_ff;

endmodule

@@ src/arp_core.sv @@
// ----------------------------------------------------------------------------
// arp_core
// Input register, instruction boundary tracking and AUIPC pair patching.
// ----------------------------------------------------------------------------
module arp_core
   import arp_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   arp_req_if.sink           req_chan,
   input  logic [WORD_W-1:0] shift_amount,
   input  logic [Q_CW-1:0]   q_count,
   output push_type          push
);

   logic            in_valid_ff;
   logic            in_valid_in;
   logic [HW_W-1:0] in_hw_ff;
   logic [HW_W-1:0] in_hw_in;
   pos_type         pos_ff;
   pos_type         pos_in;
   logic [HW_W-1:0] held0_ff, held1_ff, held2_ff;
   logic [HW_W-1:0] held0_in, held1_in, held2_in;

   logic [WORD_W-1:0] wa, wb, old_tgt, new_tgt;
   logic [11:0]       lo12;
   logic [19:0]       hi20;

   assign req_chan.ready = (q_count <= Q_CW'(RDY_LIMIT));
   assign in_valid_in    = req_chan.valid && req_chan.ready;
   assign in_hw_in       = req_chan.code_halfword;

   // pair patch: rebuild target, add displacement, rounding hi/lo split
   assign wa      = {held1_ff, held0_ff};
   assign wb      = {in_hw_ff, held2_ff};
   assign lo12    = wb[31:20];
   assign old_tgt = {wa[31:12], 12'b0} + {{20{lo12[11]}}, lo12};
   assign new_tgt = old_tgt + shift_amount;
   assign hi20    = new_tgt[31:12] + {19'b0, new_tgt[11]};

   always_comb begin
      push     = '0;
      pos_in   = pos_ff;
      held0_in = held0_ff;
      held1_in = held1_ff;
      held2_in = held2_ff;
      if (in_valid_ff) begin
         unique case (pos_ff)
            POS_PLAIN: begin
               push.num     = 3'd2;
               push.item[0] = '{halfword: held0_ff, patched: 1'b0, last: 1'b0};
               push.item[1] = '{halfword: in_hw_ff, patched: 1'b0, last: 1'b1};
               pos_in       = POS_START;
            end
            POS_PAIR1: begin
               held1_in = in_hw_ff;
               pos_in   = POS_PAIR2;
            end
            POS_PAIR2: begin
               held2_in = in_hw_ff;
               pos_in   = POS_PAIR3;
            end
            POS_PAIR3: begin
               push.num     = 3'd4;
               push.item[0] = '{halfword: {hi20[3:0], wa[11:0]}, patched: 1'b1,
                                last: 1'b0};
               push.item[1] = '{halfword: hi20[19:4], patched: 1'b1, last: 1'b0};
               push.item[2] = '{halfword: wb[15:0], patched: 1'b1, last: 1'b0};
               push.item[3] = '{halfword: {new_tgt[11:0], wb[19:16]}, patched: 1'b1,
                                last: 1'b1};
               pos_in       = POS_START;
            end
            default: begin
               if (in_hw_ff[1:0] != LEN_32) begin
                  push.num     = 3'd1;
                  push.item[0] = '{halfword: in_hw_ff, patched: 1'b0, last: 1'b1};
                  pos_in       = POS_START;
               end else begin
                  held0_in = in_hw_ff;
                  pos_in   = (in_hw_ff[6:0] == OPC_AUIPC) ? POS_PAIR1 : POS_PLAIN;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         pos_ff      <= POS_START;
      end else begin
         in_valid_ff <= in_valid_in;
         pos_ff      <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      in_hw_ff <= in_hw_in;
      held0_ff <= held0_in;
      held1_ff <= held1_in;
      held2_ff <= held2_in;
   end

   // a pushed four-entry group always ends on its last-of-run entry
   a_group_last: assert property (@(posedge clock) disable iff (reset)
      push.num == 3'd4 |-> push.item[3].last && !push.item[2].last)
      else $error("pair group not terminated correctly");

   // the word after an AUIPC always comes out as a four-entry group
   a_pair_group: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && pos_ff == POS_PAIR3 |-> push.num == 3'd4)
      else $error("pair completion did not push four entries");

endmodule

@@ src/arp_outq.sv @@
// ----------------------------------------------------------------------------
// arp_outq
// Result queue: up to four entries in a cycle, one out per cycle while ready.
// ----------------------------------------------------------------------------
module arp_outq
   import arp_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  push_type        push,
   arp_rsp_if.source       rsp_chan,
   output logic [Q_CW-1:0] q_count
);

   result_type            entries_ff [Q_DEPTH];
   logic [Q_AW-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [Q_AW-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [Q_CW-1:0]       count_ff, count_in;
   logic                  pop;
   result_type            head;

   assign head                  = entries_ff[rd_ptr_ff];
   assign rsp_chan.valid        = (count_ff != '0);
   assign rsp_chan.out_halfword = head.halfword;
   assign rsp_chan.was_patched  = head.patched;
   assign rsp_chan.last_of_run  = head.last;
   assign pop                   = rsp_chan.valid && rsp_chan.ready;
   assign q_count               = count_ff;

   assign wr_ptr_in = wr_ptr_ff + Q_AW'(push.num);
   assign rd_ptr_in = rd_ptr_ff + Q_AW'(pop);
   assign count_in  = count_ff + Q_CW'(push.num) - Q_CW'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < MAX_RESULTS; k++) begin
         if (3'(k) < push.num) begin
            entries_ff[wr_ptr_ff + Q_AW'(k)] <= push.item[k];
         end
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      count_ff <= Q_CW'(Q_DEPTH))
      else $error("result queue overflow");

   a_count_track: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |->
         count_ff == $past(count_ff) + Q_CW'($past(push.num)) - Q_CW'($past(pop)))
      else $error("queue count out of step with push and pop");

   // entries of a group are pushed together, so a non-last head has a successor
   a_group_whole: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.last_of_run |-> count_ff >= Q_CW'(2))
      else $error("partial group at queue head");

endmodule
